>>> sv/gfrtn_pkg.sv
// Shared types, codes and sizing helpers for the grayscale frame engine.
// No dependencies; every other file refers to this package by scoped names.
package gfrtn_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int MID_DEPTH      = 4;
  localparam int OUT_DEPTH      = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int SIZE_W     = 10;
  localparam int PIX_W      = 8;

  // command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // pixel operation codes
  localparam logic [1:0] OP_PASS   = 2'd0;
  localparam logic [1:0] OP_NEG    = 2'd1;
  localparam logic [1:0] OP_THRESH = 2'd2;

  // rotation codes
  localparam logic [1:0] ROT_NONE  = 2'd0;
  localparam logic [1:0] ROT_LEFT  = 2'd1;
  localparam logic [1:0] ROT_RIGHT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_OP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 3'd4;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 10'd512;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 10'd512;
  localparam logic [PIX_W-1:0]  MAX_RST    = 8'd255;

  // what the back end does with one queued item
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic             err;
    logic             last;
    logic             mono;
    logic [PIX_W-1:0] wdata;
  } ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] max_value;
    logic [1:0]       pixel_op;
  } opcfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             mono;
    logic             err;
  } res_t;

  // index width for n entries, at least one bit
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

>>> sv/gfrtn_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on gfrtn_pkg for index sizing.
module gfrtn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [gfrtn_pkg::idx_w(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [gfrtn_pkg::idx_w(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/gfrtn_fifo.sv
// Small register FIFO with occupancy count; depth must be a power of two.
// Depends on gfrtn_pkg for index sizing.
module gfrtn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [WIDTH-1:0]              wdata,
  output logic                          full,
  input  logic                          pop,
  output logic [WIDTH-1:0]              rdata,
  output logic                          empty,
  output logic [$clog2(DEPTH+1)-1:0]    count
);

  localparam int PW = gfrtn_pkg::idx_w(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == NW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointers wrap naturally at a power-of-two depth
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

>>> sv/gfrtn_front.sv
// Front end: config registers, command decode, write/read counters, mono flag
// and source address generation. Depends on gfrtn_pkg.
module gfrtn_front #(
  parameter int MAX_WIDTH  = gfrtn_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gfrtn_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [1:0]                            in_command,
  input  logic [gfrtn_pkg::PIX_W-1:0]           in_pixel_in,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gfrtn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gfrtn_pkg::CFG_DATA_W-1:0]      cfg_data,
  output gfrtn_pkg::opcfg_t                     op_cfg,
  input  logic                                  q_full,
  output logic                                  q_push,
  output gfrtn_pkg::ctl_t                       q_ctl,
  output logic [gfrtn_pkg::idx_w(MAX_WIDTH*MAX_HEIGHT)-1:0] q_addr
);

  localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW   = $clog2(MAXD + 1);
  localparam int CW   = gfrtn_pkg::idx_w(MAXD);
  localparam int AW   = gfrtn_pkg::idx_w(MAX_WIDTH * MAX_HEIGHT);
  localparam int TW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SW   = gfrtn_pkg::SIZE_W;
  localparam int PW   = gfrtn_pkg::PIX_W;

  // clamped reset sizes and their product
  localparam int W_RST = (int'(gfrtn_pkg::WIDTH_RST) == 0) ? 1 :
                         (int'(gfrtn_pkg::WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH :
                         int'(gfrtn_pkg::WIDTH_RST);
  localparam int H_RST = (int'(gfrtn_pkg::HEIGHT_RST) == 0) ? 1 :
                         (int'(gfrtn_pkg::HEIGHT_RST) > MAX_HEIGHT) ? MAX_HEIGHT :
                         int'(gfrtn_pkg::HEIGHT_RST);
  localparam int TOTAL_RST = W_RST * H_RST;

  function automatic logic [DW-1:0] clamp_size(input logic [SW-1:0] v,
                                               input logic [DW-1:0] hi);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if ({{DW{1'b0}}, v} > {{SW{1'b0}}, hi}) begin
      r = hi;
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  logic [SW-1:0] width_r, width_nxt;
  logic [SW-1:0] height_r, height_nxt;
  logic [PW-1:0] maxv_r, maxv_nxt;
  logic [1:0]    pop_r, pop_nxt;
  logic [1:0]    rot_r, rot_nxt;
  logic [DW-1:0] w_r, w_nxt;
  logic [DW-1:0] h_r, h_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [2*DW-1:0] size_prod;

  logic [TW-1:0] wcnt_r, wcnt_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          mono_r, mono_nxt;

  logic          accept;
  logic          loaded;
  logic          rotated;
  logic [DW-1:0] ow, oh;
  logic [CW-1:0] r_eff, c_eff;
  logic [DW-1:0] r_ext, c_ext;
  logic [DW-1:0] mul_a, add_b;
  logic [2*DW-1:0] src_full;
  logic          at_col_end, at_last;
  gfrtn_pkg::ctl_t ctl;
  logic [AW-1:0] addr;

  assign cfg_ready = 1'b1;

  // config next values; sizes and their product are registered alongside
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    maxv_nxt   = maxv_r;
    pop_nxt    = pop_r;
    rot_nxt    = rot_r;
    if (cfg_valid) begin
      case (cfg_index)
        gfrtn_pkg::REG_WIDTH:    width_nxt  = cfg_data;
        gfrtn_pkg::REG_HEIGHT:   height_nxt = cfg_data;
        gfrtn_pkg::REG_MAX:      maxv_nxt   = cfg_data[PW-1:0];
        gfrtn_pkg::REG_PIXEL_OP: pop_nxt    = cfg_data[1:0];
        gfrtn_pkg::REG_ROTATION: rot_nxt    = cfg_data[1:0];
        default: ;
      endcase
    end
    w_nxt     = clamp_size(width_nxt, DW'(MAX_WIDTH));
    h_nxt     = clamp_size(height_nxt, DW'(MAX_HEIGHT));
    size_prod = {{DW{1'b0}}, w_nxt} * {{DW{1'b0}}, h_nxt};
    total_nxt = size_prod[TW-1:0];
  end

  assign accept  = in_push && !q_full;
  assign in_full = q_full;
  assign loaded  = (wcnt_r >= total_r);
  assign rotated = (rot_r == gfrtn_pkg::ROT_LEFT) || (rot_r == gfrtn_pkg::ROT_RIGHT);
  assign ow      = rotated ? h_r : w_r;
  assign oh      = rotated ? w_r : h_r;

  // a size change can leave the read position outside the frame
  always_comb begin
    if ((DW'(row_r) >= oh) || (DW'(col_r) >= ow)) begin
      r_eff = '0;
      c_eff = '0;
    end else begin
      r_eff = row_r;
      c_eff = col_r;
    end
    r_ext = DW'(r_eff);
    c_ext = DW'(c_eff);
  end

  always_comb begin
    case (rot_r)
      gfrtn_pkg::ROT_LEFT: begin
        mul_a = c_ext;
        add_b = w_r - DW'(1) - r_ext;
      end
      gfrtn_pkg::ROT_RIGHT: begin
        mul_a = h_r - DW'(1) - c_ext;
        add_b = r_ext;
      end
      default: begin
        mul_a = r_ext;
        add_b = c_ext;
      end
    endcase
    src_full = ({{DW{1'b0}}, mul_a} * {{DW{1'b0}}, w_r}) + {{DW{1'b0}}, add_b};
  end

  assign at_col_end = (c_ext == ow - DW'(1));
  assign at_last    = at_col_end && (r_ext == oh - DW'(1));

  always_comb begin
    wcnt_nxt = wcnt_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    mono_nxt = mono_r;
    ctl      = '{kind: gfrtn_pkg::KIND_NONE, err: 1'b0, last: 1'b0, mono: 1'b0,
                 wdata: in_pixel_in};
    addr     = '0;
    unique case (in_command)
      gfrtn_pkg::CMD_START: begin
        wcnt_nxt = '0;
        row_nxt  = '0;
        col_nxt  = '0;
        mono_nxt = 1'b1;
      end
      gfrtn_pkg::CMD_WRITE: begin
        if (loaded) begin
          ctl.err = 1'b1;
        end else begin
          ctl.kind = gfrtn_pkg::KIND_WRITE;
          addr     = wcnt_r[AW-1:0];
          wcnt_nxt = wcnt_r + TW'(1);
          if ((in_pixel_in != '0) && (in_pixel_in != maxv_r)) begin
            mono_nxt = 1'b0;
          end
        end
      end
      gfrtn_pkg::CMD_READ: begin
        if (!loaded) begin
          ctl.err = 1'b1;
        end else begin
          ctl.kind = gfrtn_pkg::KIND_READ;
          ctl.last = at_last;
          ctl.mono = (pop_r == gfrtn_pkg::OP_THRESH) && mono_r;
          addr     = src_full[AW-1:0];
          if (at_last) begin
            row_nxt = '0;
            col_nxt = '0;
          end else if (at_col_end) begin
            row_nxt = r_eff + CW'(1);
            col_nxt = '0;
          end else begin
            row_nxt = r_eff;
            col_nxt = c_eff + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gfrtn_pkg::WIDTH_RST;
      height_r <= gfrtn_pkg::HEIGHT_RST;
      maxv_r   <= gfrtn_pkg::MAX_RST;
      pop_r    <= gfrtn_pkg::OP_PASS;
      rot_r    <= gfrtn_pkg::ROT_NONE;
      w_r      <= DW'(W_RST);
      h_r      <= DW'(H_RST);
      total_r  <= TW'(TOTAL_RST);
      wcnt_r   <= '0;
      row_r    <= '0;
      col_r    <= '0;
      mono_r   <= 1'b1;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      maxv_r   <= maxv_nxt;
      pop_r    <= pop_nxt;
      rot_r    <= rot_nxt;
      w_r      <= w_nxt;
      h_r      <= h_nxt;
      total_r  <= total_nxt;
      if (accept) begin
        wcnt_r <= wcnt_nxt;
        row_r  <= row_nxt;
        col_r  <= col_nxt;
        mono_r <= mono_nxt;
      end
    end
  end

  assign q_push         = accept;
  assign q_ctl          = ctl;
  assign q_addr         = addr;
  assign op_cfg.max_value = maxv_r;
  assign op_cfg.pixel_op  = pop_r;

endmodule

>>> sv/gfrtn_back.sv
// Back end: frame store access, pixel operation and result queue.
// Depends on gfrtn_pkg, gfrtn_ram and gfrtn_fifo.
module gfrtn_back #(
  parameter int MAX_WIDTH  = gfrtn_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gfrtn_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_empty,
  output logic                                  q_pop,
  input  gfrtn_pkg::ctl_t                       q_ctl,
  input  logic [gfrtn_pkg::idx_w(MAX_WIDTH*MAX_HEIGHT)-1:0] q_addr,
  input  gfrtn_pkg::opcfg_t                     op_cfg,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output gfrtn_pkg::res_t                       out_res
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int PW    = gfrtn_pkg::PIX_W;
  localparam int OD    = gfrtn_pkg::OUT_DEPTH;
  localparam int NW    = $clog2(OD + 1);
  localparam int RW    = $bits(gfrtn_pkg::res_t);

  logic            issue;
  logic [NW-1:0]   ocount;
  logic            s1_valid_r;
  gfrtn_pkg::ctl_t s1_ctl_r;
  logic [PW-1:0]   rdata;
  logic [PW-1:0]   proc_pix;
  gfrtn_pkg::res_t res;
  logic [RW-1:0]   res_q;

  // keep a slot for the beat still in the read stage
  assign issue = !q_empty && ({1'b0, ocount} + {{NW{1'b0}}, s1_valid_r} < (NW+1)'(OD));
  assign q_pop = issue;

  gfrtn_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (issue && (q_ctl.kind == gfrtn_pkg::KIND_WRITE)),
    .waddr (q_addr),
    .wdata (q_ctl.wdata),
    .re    (issue && (q_ctl.kind == gfrtn_pkg::KIND_READ)),
    .raddr (q_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ctl_r <= q_ctl;
    end
  end

  always_comb begin
    case (op_cfg.pixel_op)
      gfrtn_pkg::OP_NEG: proc_pix = op_cfg.max_value - rdata;
      gfrtn_pkg::OP_THRESH: begin
        if (s1_ctl_r.mono) begin
          proc_pix = rdata;
        end else if (rdata > (op_cfg.max_value >> 1)) begin
          proc_pix = op_cfg.max_value;
        end else begin
          proc_pix = '0;
        end
      end
      default: proc_pix = rdata;
    endcase
    res.pixel = (s1_ctl_r.kind == gfrtn_pkg::KIND_READ) ? proc_pix : '0;
    res.last  = s1_ctl_r.last;
    res.mono  = s1_ctl_r.mono;
    res.err   = s1_ctl_r.err;
  end

  // the issue check reserves room, so the output queue never sees a push when full
  gfrtn_fifo #(
    .WIDTH (RW),
    .DEPTH (OD)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s1_valid_r),
    .wdata (res),
    .full  (),
    .pop   (out_pop),
    .rdata (res_q),
    .empty (out_empty),
    .count (ocount)
  );

  assign out_res = gfrtn_pkg::res_t'(res_q);

endmodule

>>> sv/gray_frame_rotate_threshold_negate_top.sv
// Grayscale frame engine: rotate 0/90 left/90 right, negate or threshold.
// A result passes the mid queue, the frame store read stage and the output queue.
// Throughput: one command per cycle while in_full is low; front and back meet
// at a 4-entry queue, results leave through a 4-entry output queue.
// Reset (rst_n low, synchronous): counters cleared, mono flag set, registers
// at defaults; the frame store is not cleared and reads as written only.
module gray_frame_rotate_threshold_negate_top #(
  parameter int MAX_WIDTH  = gfrtn_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gfrtn_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [1:0]                        in_command,
  input  logic [gfrtn_pkg::PIX_W-1:0]       in_pixel_in,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [gfrtn_pkg::PIX_W-1:0]       out_pixel_out,
  output logic                              out_last_pixel,
  output logic                              out_already_mono,
  output logic                              out_op_error,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gfrtn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gfrtn_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = gfrtn_pkg::idx_w(MAX_WIDTH * MAX_HEIGHT);
  localparam int CTW = $bits(gfrtn_pkg::ctl_t);
  localparam int QW = CTW + AW;

  gfrtn_pkg::opcfg_t op_cfg;
  gfrtn_pkg::ctl_t   f_ctl, b_ctl;
  logic [AW-1:0]     f_addr, b_addr;
  logic              q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]     q_rdata;
  gfrtn_pkg::res_t   res;

  gfrtn_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_command  (in_command),
    .in_pixel_in (in_pixel_in),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .op_cfg      (op_cfg),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_ctl       (f_ctl),
    .q_addr      (f_addr)
  );

  gfrtn_fifo #(
    .WIDTH (QW),
    .DEPTH (gfrtn_pkg::MID_DEPTH)
  ) u_midq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_ctl, f_addr}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count ()
  );

  assign b_ctl  = gfrtn_pkg::ctl_t'(q_rdata[QW-1:AW]);
  assign b_addr = q_rdata[AW-1:0];

  gfrtn_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_ctl     (b_ctl),
    .q_addr    (b_addr),
    .op_cfg    (op_cfg),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  assign out_pixel_out    = res.pixel;
  assign out_last_pixel   = res.last;
  assign out_already_mono = res.mono;
  assign out_op_error     = res.err;

endmodule

>>> verif/gfrtn_frame_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the grayscale frame engine: follows the command, result and
// register channels, predicts each result beat and compares it field by field.
// Depends on gfrtn_pkg for the codes, sizes and the result struct.
module gfrtn_frame_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic                             in_full,
  input  logic [1:0]                       in_command,
  input  logic [gfrtn_pkg::PIX_W-1:0]      in_pixel_in,
  input  logic                             out_empty,
  input  logic                             out_pop,
  input  logic [gfrtn_pkg::PIX_W-1:0]      out_pixel_out,
  input  logic                             out_last_pixel,
  input  logic                             out_already_mono,
  input  logic                             out_op_error,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [gfrtn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gfrtn_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               fail_count,
  output int                               outstanding
);

  localparam int          PW      = gfrtn_pkg::PIX_W;
  localparam int          SW      = gfrtn_pkg::SIZE_W;
  localparam int unsigned FRAME_W = gfrtn_pkg::MAX_WIDTH_DEF;
  localparam int unsigned FRAME_H = gfrtn_pkg::MAX_HEIGHT_DEF;

  // shadow of the engine
  logic [PW-1:0]  pix_mem [0:FRAME_W*FRAME_H-1];
  int unsigned    wr_count, rd_row, rd_col;
  logic           mono_all;
  logic [SW-1:0]  width_reg, height_reg;
  logic [PW-1:0]  max_reg;
  logic [1:0]     op_reg, rot_reg;

  gfrtn_pkg::res_t expected_px_q[$];
  int              mismatch_total = 0;

  assign fail_count = mismatch_total;

  function automatic int unsigned eff_size(input logic [SW-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // advance the shadow by one command beat and return the result it yields
  function automatic gfrtn_pkg::res_t frame_engine_step(input logic [1:0] cmd,
                                                        input logic [PW-1:0] pix);
    gfrtn_pkg::res_t r;
    int unsigned     w, h, total, ow, oh, row, col, src;
    logic [PW-1:0]   p;
    r     = '0;
    w     = eff_size(width_reg, FRAME_W);
    h     = eff_size(height_reg, FRAME_H);
    total = w * h;
    case (cmd)
      gfrtn_pkg::CMD_START: begin
        wr_count = 0;
        rd_row   = 0;
        rd_col   = 0;
        mono_all = 1'b1;
      end
      gfrtn_pkg::CMD_WRITE: begin
        if (wr_count >= total) begin
          r.err = 1'b1;
        end else begin
          pix_mem[wr_count] = pix;
          if (pix != 0 && pix != max_reg) mono_all = 1'b0;
          wr_count++;
        end
      end
      gfrtn_pkg::CMD_READ: begin
        if (wr_count < total) begin
          r.err = 1'b1;
        end else begin
          if (rot_reg == gfrtn_pkg::ROT_LEFT || rot_reg == gfrtn_pkg::ROT_RIGHT) begin
            ow = h;
            oh = w;
          end else begin
            ow = w;
            oh = h;
          end
          // a size change may leave the position outside the output frame
          if (rd_row >= oh || rd_col >= ow) begin
            rd_row = 0;
            rd_col = 0;
          end
          row = rd_row;
          col = rd_col;
          case (rot_reg)
            gfrtn_pkg::ROT_LEFT:  src = col * w + (w - 1 - row);
            gfrtn_pkg::ROT_RIGHT: src = (h - 1 - col) * w + row;
            default:              src = row * w + col;
          endcase
          p = pix_mem[src];
          case (op_reg)
            gfrtn_pkg::OP_NEG: r.pixel = max_reg - p;
            gfrtn_pkg::OP_THRESH: begin
              if (mono_all) begin
                r.mono  = 1'b1;
                r.pixel = p;
              end else begin
                r.pixel = (p > (max_reg >> 1)) ? max_reg : '0;
              end
            end
            default: r.pixel = p;
          endcase
          if (row == oh - 1 && col == ow - 1) begin
            r.last = 1'b1;
            rd_row = 0;
            rd_col = 0;
          end else if (col == ow - 1) begin
            rd_col = 0;
            rd_row = row + 1;
          end else begin
            rd_col = col + 1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    gfrtn_pkg::res_t want;
    if (!rst_n) begin
      wr_count   = 0;
      rd_row     = 0;
      rd_col     = 0;
      mono_all   = 1'b1;
      width_reg  = gfrtn_pkg::WIDTH_RST;
      height_reg = gfrtn_pkg::HEIGHT_RST;
      max_reg    = gfrtn_pkg::MAX_RST;
      op_reg     = gfrtn_pkg::OP_PASS;
      rot_reg    = gfrtn_pkg::ROT_NONE;
      expected_px_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gfrtn_pkg::REG_WIDTH:    width_reg  = cfg_data;
          gfrtn_pkg::REG_HEIGHT:   height_reg = cfg_data;
          gfrtn_pkg::REG_MAX:      max_reg    = cfg_data[PW-1:0];
          gfrtn_pkg::REG_PIXEL_OP: op_reg     = cfg_data[1:0];
          gfrtn_pkg::REG_ROTATION: rot_reg    = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full)
        expected_px_q.push_back(frame_engine_step(in_command, in_pixel_in));
      if (out_pop && !out_empty) begin
        if (expected_px_q.size() == 0) begin
          $error("result beat with nothing expected: pixel_out %0d", out_pixel_out);
          mismatch_total++;
        end else begin
          want = expected_px_q.pop_front();
          if (out_pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel, out_pixel_out);
            mismatch_total++;
          end
          if (out_last_pixel !== want.last) begin
            $error("last_pixel: expected %0d, got %0d", want.last, out_last_pixel);
            mismatch_total++;
          end
          if (out_already_mono !== want.mono) begin
            $error("already_mono: expected %0d, got %0d", want.mono, out_already_mono);
            mismatch_total++;
          end
          if (out_op_error !== want.err) begin
            $error("op_error: expected %0d, got %0d", want.err, out_op_error);
            mismatch_total++;
          end
        end
      end
      outstanding <= expected_px_q.size();
    end
  end

endmodule

>>> verif/tb_gray_frame_rotate_threshold_negate_top.sv
`timescale 1ns / 1ps
// Testbench top for the grayscale frame engine: clock, reset, command and
// register stimulus, result back-pressure and the verdict.
// Depends on gfrtn_pkg, the engine RTL and gfrtn_frame_checker.
module tb_gray_frame_rotate_threshold_negate_top;

  localparam int PW  = gfrtn_pkg::PIX_W;
  localparam int SW  = gfrtn_pkg::SIZE_W;
  localparam int IW  = gfrtn_pkg::CFG_IDX_W;
  localparam int CDW = gfrtn_pkg::CFG_DATA_W;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int unsigned RANDOM_BEATS = 1300;
  localparam int HOLD_FRAME  = 2;
  localparam int BIG_FRAME   = 5;
  localparam int HOLD_CYCLES = 400;

  logic           clk;
  logic           rst_n       = 1'b0;
  logic           in_push     = 1'b0;
  logic [1:0]     in_command  = gfrtn_pkg::CMD_START;
  logic [PW-1:0]  in_pixel_in = '0;
  logic           out_pop     = 1'b0;
  logic           cfg_valid   = 1'b0;
  logic [IW-1:0]  cfg_index   = gfrtn_pkg::REG_WIDTH;
  logic [CDW-1:0] cfg_data    = '0;
  logic           in_full, out_empty, cfg_ready;
  logic [PW-1:0]  out_pixel_out;
  logic           out_last_pixel, out_already_mono, out_op_error;
  int             fail_count, outstanding;

  int            hold_token = 0;
  int unsigned   beats_sent = 0;
  int unsigned   burst_left = 0;
  logic [PW-1:0] max_set    = gfrtn_pkg::MAX_RST;

  gray_frame_rotate_threshold_negate_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_pixel_in      (in_pixel_in),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_out    (out_pixel_out),
    .out_last_pixel   (out_last_pixel),
    .out_already_mono (out_already_mono),
    .out_op_error     (out_op_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  gfrtn_frame_checker frame_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_pixel_in      (in_pixel_in),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_out    (out_pixel_out),
    .out_last_pixel   (out_last_pixel),
    .out_already_mono (out_already_mono),
    .out_op_error     (out_op_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_gray_frame_rotate_threshold_negate_top: errors");
    $finish;
  end

  // result side: stall modes of varying length, plus a long hold-off on request
  initial begin : receiver
    int unsigned mode, mode_left, hold_seen;
    mode      = 0;
    mode_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        case (mode)
          0:       out_pop <= 1'b1;
          1:       out_pop <= 1'($urandom_range(0, 1));
          2:       out_pop <= (mode_left % 4 == 0);
          default: out_pop <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic logic [PW-1:0] rand_pix();
    return PW'($urandom_range(0, 255));
  endfunction

  function automatic logic [PW-1:0] rand_max();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd1;
    return PW'($urandom_range(1, 255));
  endfunction

  function automatic logic [PW-1:0] fill_pixel(input bit mono);
    if (mono) return $urandom_range(0, 1) ? max_set : '0;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return max_set;
      default: return rand_pix();
    endcase
  endfunction

  function automatic int unsigned dim_of(input logic [SW-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // one command beat, in bursts with random gaps between them
  task automatic send_beat(input logic [1:0] cmd, input logic [PW-1:0] pix);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_push     <= 1'b0;
        in_command  <= 2'($urandom_range(0, 3));
        in_pixel_in <= rand_pix();
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_push     <= 1'b1;
    in_command  <= cmd;
    in_pixel_in <= pix;
    do @(posedge clk); while (in_full);
    beats_sent++;
  endtask

  // stop sending and wait until every result beat has been taken
  task automatic wait_idle();
    in_push     <= 1'b0;
    in_command  <= 2'($urandom_range(0, 3));
    in_pixel_in <= rand_pix();
    burst_left  = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // valid is left high; the caller drops it after the last write of a batch
  task automatic write_reg(input logic [IW-1:0] idx, input logic [CDW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == gfrtn_pkg::REG_MAX) max_set = val[PW-1:0];
  endtask

  task automatic configure(input logic [SW-1:0] w, input logic [SW-1:0] h,
                           input logic [PW-1:0] mx, input logic [1:0] op,
                           input logic [1:0] rot);
    wait_idle();
    write_reg(gfrtn_pkg::REG_WIDTH, w);
    write_reg(gfrtn_pkg::REG_HEIGHT, h);
    write_reg(gfrtn_pkg::REG_MAX, CDW'(mx));
    write_reg(gfrtn_pkg::REG_PIXEL_OP, CDW'(op));
    write_reg(gfrtn_pkg::REG_ROTATION, CDW'(rot));
    cfg_valid <= 1'b0;
  endtask

  // a load followed by reads, with noise, size changes and restarts mixed in
  task automatic run_frame(input int frame_no);
    int unsigned   w, h, total, n_reads, i, k;
    logic [SW-1:0] wr, hr;
    bit            big, mono_fill;
    big = (frame_no == BIG_FRAME);
    if (big) begin
      case ($urandom_range(0, 2))
        0:       wr = 10'd512;
        1:       wr = 10'd513;
        default: wr = 10'd1023;
      endcase
      hr = SW'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
        hr = wr;
        wr = SW'($urandom_range(0, 1));
      end
    end else if (frame_no == HOLD_FRAME) begin
      wr = 10'd8;
      hr = 10'd8;
    end else begin
      wr = ($urandom_range(0, 24) == 0) ? 10'd0 : 10'($urandom_range(1, 8));
      hr = ($urandom_range(0, 24) == 0) ? 10'd0 : 10'($urandom_range(1, 8));
    end
    configure(wr, hr, rand_max(), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
    w     = dim_of(wr, gfrtn_pkg::MAX_WIDTH_DEF);
    h     = dim_of(hr, gfrtn_pkg::MAX_HEIGHT_DEF);
    total = w * h;

    send_beat(gfrtn_pkg::CMD_START, rand_pix());
    // receiver holds off while the whole load keeps coming
    if (frame_no == HOLD_FRAME) hold_token <= hold_token + 1;
    mono_fill = ($urandom_range(0, 2) == 0);
    i = 0;
    while (i < total) begin
      k = $urandom_range(0, 39);
      if (k == 0) begin
        send_beat(gfrtn_pkg::CMD_READ, rand_pix());
      end else if (k == 1) begin
        send_beat(CMD_UNUSED, rand_pix());
      end else if (k == 2 && !big) begin
        send_beat(gfrtn_pkg::CMD_START, rand_pix());
        i = 0;
      end else if (k == 3 && !big) begin
        // max changes mid-load, so the mono test follows the new level
        wait_idle();
        write_reg(gfrtn_pkg::REG_MAX, CDW'(rand_max()));
        cfg_valid <= 1'b0;
      end
      send_beat(gfrtn_pkg::CMD_WRITE, fill_pixel(mono_fill));
      i++;
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 2)) send_beat(gfrtn_pkg::CMD_WRITE, rand_pix());

    if (big) n_reads = $urandom_range(0, 1) ? total + 2 : 24;
    else n_reads = $urandom_range(1, 2 * total + 1);
    for (i = 0; i < n_reads; i++) begin
      k = $urandom_range(0, 39);
      if (k == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0:       write_reg(gfrtn_pkg::REG_PIXEL_OP, CDW'($urandom_range(0, 3)));
          1:       write_reg(gfrtn_pkg::REG_ROTATION, CDW'($urandom_range(0, 3)));
          2:       write_reg(gfrtn_pkg::REG_WIDTH, CDW'($urandom_range(1, w)));
          default: write_reg(gfrtn_pkg::REG_HEIGHT, CDW'($urandom_range(1, h)));
        endcase
        cfg_valid <= 1'b0;
      end else if (k == 1 && !big) begin
        send_beat(CMD_UNUSED, rand_pix());
      end else if (k == 2 && !big) begin
        send_beat(gfrtn_pkg::CMD_START, rand_pix());
      end
      send_beat(gfrtn_pkg::CMD_READ, rand_pix());
    end
    if (big && n_reads < total) begin
      // shrink a partly read frame: the read position falls outside
      wait_idle();
      write_reg(gfrtn_pkg::REG_WIDTH, CDW'($urandom_range(1, 4)));
      write_reg(gfrtn_pkg::REG_HEIGHT, 10'd1);
      cfg_valid <= 1'b0;
      repeat (12) send_beat(gfrtn_pkg::CMD_READ, rand_pix());
    end
  endtask

  initial begin : stimulus
    int frame_no;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size is 512x512 with nothing loaded
    send_beat(gfrtn_pkg::CMD_READ, 8'h00);
    send_beat(CMD_UNUSED, 8'hFF);

    // monochrome frame under threshold, write past end, wrap after last pixel
    configure(10'd2, 10'd2, 8'd255, gfrtn_pkg::OP_THRESH, gfrtn_pkg::ROT_NONE);
    send_beat(gfrtn_pkg::CMD_START, 8'hAA);
    send_beat(gfrtn_pkg::CMD_WRITE, 8'h00);
    send_beat(gfrtn_pkg::CMD_WRITE, 8'hFF);
    send_beat(gfrtn_pkg::CMD_WRITE, 8'hFF);
    send_beat(gfrtn_pkg::CMD_WRITE, 8'h00);
    send_beat(gfrtn_pkg::CMD_WRITE, 8'h55);
    repeat (5) send_beat(gfrtn_pkg::CMD_READ, 8'h00);

    // negate with wrap, rotated left
    configure(10'd2, 10'd2, 8'd200, gfrtn_pkg::OP_NEG, gfrtn_pkg::ROT_LEFT);
    send_beat(gfrtn_pkg::CMD_START, 8'h00);
    send_beat(gfrtn_pkg::CMD_WRITE, 8'd1);
    send_beat(gfrtn_pkg::CMD_WRITE, 8'd128);
    send_beat(gfrtn_pkg::CMD_WRITE, 8'd200);
    send_beat(gfrtn_pkg::CMD_WRITE, 8'd255);
    repeat (4) send_beat(gfrtn_pkg::CMD_READ, 8'hFF);

    // zero width counts as one, threshold at the lowest max, rotated right
    configure(10'd0, 10'd2, 8'd1, gfrtn_pkg::OP_THRESH, gfrtn_pkg::ROT_RIGHT);
    send_beat(gfrtn_pkg::CMD_START, 8'h00);
    send_beat(gfrtn_pkg::CMD_WRITE, 8'd1);
    send_beat(gfrtn_pkg::CMD_WRITE, 8'd2);
    repeat (2) send_beat(gfrtn_pkg::CMD_READ, 8'h00);

    frame_no = 0;
    while (frame_no <= BIG_FRAME || beats_sent < RANDOM_BEATS) begin
      run_frame(frame_no);
      frame_no++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("tb_gray_frame_rotate_threshold_negate_top: clean");
    else
      $display("tb_gray_frame_rotate_threshold_negate_top: errors");
    $finish;
  end

endmodule
